// File: sv/fas_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package fas_pkg;
   localparam int unsigned SigWidth = 24;
   localparam int unsigned ExpWidth = 8;
   localparam int unsigned FracWidth = 23;

   typedef struct packed {
      logic [31:0] operand_a;
      logic [31:0] operand_b;
      logic        action;
   } req_word_type;

   typedef struct packed {
      logic [31:0] result;
      logic        exponent_range_error;
   } rsp_word_type;

   // count of leading zeros in a 25-bit value, at most 25
   function automatic logic [4:0] lead_zeros(input logic [24:0] v);
      logic [4:0] n;
      logic       hit;
      n = 5'd25;
      hit = 1'b0;
      for (int i = 24; i >= 0; i--) begin
         if (!hit && v[i]) begin
            n = 5'(24 - i);
            hit = 1'b1;
         end
      end
      return n;
   endfunction
endpackage
`default_nettype wire

// File: sv/fas_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface fas_req_if import fas_pkg::*; ();
   logic         valid;
   logic         ready;
   req_word_type word;
   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

interface fas_rsp_if import fas_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_word_type word;
   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface
`default_nettype wire

// File: sv/fas_core.sv
`timescale 1ns / 1ps
`default_nettype none
module fas_core import fas_pkg::*; (
   input  req_word_type req_word,
   output rsp_word_type rsp_word
);
   logic        sa, sb, is_sub, a_first;
   logic [7:0]  ea, eb, e_big, e_sml;
   logic [23:0] ma, mb, m_big, m_sml, shifted;
   logic [8:0]  d9;
   logic [7:0]  d;
   logic        borrow, sign, neg;
   logic [24:0] sum, diff;
   logic [4:0]  lz;
   logic [9:0]  exp;
   logic [23:0] sig;

   always_comb begin
      sa = req_word.operand_a[31];
      sb = req_word.operand_b[31] ^ req_word.action;
      ea = req_word.operand_a[30:23];
      eb = req_word.operand_b[30:23];
      ma = {1'b1, req_word.operand_a[22:0]};
      mb = {1'b1, req_word.operand_b[22:0]};
      is_sub = sa != sb;
      // subtract order: x is a when a positive
      a_first = (ea > eb) || (ea == eb && ma >= mb);
      if (a_first) begin
         e_big = ea; m_big = ma; e_sml = eb; m_sml = mb;
      end else begin
         e_big = eb; m_big = mb; e_sml = ea; m_sml = ma;
      end
      d9 = {1'b0, e_big} - {1'b0, e_sml};
      d = d9[7:0];
      shifted = (d >= 8'd24) ? 24'd0 : (m_sml >> d[4:0]);
      borrow = 1'b0;
      if (d >= 8'd1 && d <= 8'd24) begin
         borrow = m_sml[5'(d - 8'd1)];
      end
      sum = {1'b0, m_big} + {1'b0, shifted};
      diff = {1'b0, m_big} - {1'b0, shifted} - {24'd0, borrow};
      lz = lead_zeros(diff);
      // x greater gives sign 0; x is a when sa is 0
      neg = sa ? a_first : !a_first;
      sign = sa;
      exp = {2'b00, e_big};
      sig = sum[23:0];
      rsp_word.exponent_range_error = 1'b0;
      rsp_word.result = '0;
      if (!is_sub) begin
         if (sum[24]) begin
            sig = sum[24:1];
            exp = exp + 10'd1;
         end
         rsp_word.result = {sign, exp[7:0], sig[22:0]};
         rsp_word.exponent_range_error = exp[9] | exp[8];
      end else if (diff != 25'd0) begin
         // diff below 2^24 always; lz at least 1
         sig = 24'(diff << (lz - 5'd1));
         exp = exp - {5'd0, lz} + 10'd1;
         rsp_word.result = {neg, exp[7:0], sig[22:0]};
         rsp_word.exponent_range_error = exp[9] | exp[8];
      end
   end
endmodule
`default_nettype wire

// File: sv/float32_add_sub.sv
`timescale 1ns / 1ps
`default_nettype none
// Single-precision add/subtract with truncation, no special encodings. One word
// is accepted per cycle while ready is high. Its result goes from an input
// register through one combinational datapath into a result register, or into
// a holding register when the output is stalled. The holding register keeps
// one word while the output is stalled, and the input drops ready only while
// that register is full.
module float32_add_sub import fas_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   fas_req_if.sink   req,
   fas_rsp_if.source rsp
);
   req_word_type in_ff;
   logic         in_vld_ff;
   rsp_word_type calc;
   rsp_word_type out_ff, skid_ff;
   logic         out_vld_ff, skid_vld_ff;
   logic         adv;

   fas_core u_core (.req_word(in_ff), .rsp_word(calc));

   assign req.ready = !skid_vld_ff;
   assign rsp.valid = out_vld_ff;
   assign rsp.word  = out_ff;
   assign adv = !out_vld_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         if (req.ready) begin
            in_vld_ff <= req.valid;
            in_ff <= req.word;
         end
         if (adv) begin
            if (skid_vld_ff) begin
               out_ff <= skid_ff;
               out_vld_ff <= 1'b1;
               skid_vld_ff <= 1'b0;
            end else begin
               out_ff <= calc;
               out_vld_ff <= in_vld_ff;
            end
         end else if (!skid_vld_ff && in_vld_ff) begin
            skid_ff <= calc;
            skid_vld_ff <= 1'b1;
         end
      end
   end
endmodule
`default_nettype wire

// File: sv/fas_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module fas_checker import fas_pkg::*; (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_valid,
   input wire logic         req_ready,
   input wire logic         rsp_valid,
   input wire logic         rsp_ready,
   input wire rsp_word_type rsp_word
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("stalled word changed");
   a_flow: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready ##1 1'b1 |=> rsp_valid)
      else $error("accepted word not delivered");
   a_rst: assert property (@(posedge clock) $past(reset) && !reset |-> !rsp_valid)
      else $error("valid after reset");
endmodule

bind float32_add_sub fas_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_word(rsp.word)
);
`default_nettype wire
